@@ hdl/sfd_pkg.sv @@
// Package for the serial frame decoder: shared types, frame layout constants,
// register index codes and decode constants. No dependencies.
package sfd_pkg;

   localparam int BYTE_W      = 8;
   localparam int PAYLOAD_LEN = 23;   // stored bytes per frame, flag byte included
   localparam int FLAG_BYTE   = 22;
   localparam int DATA_BYTES  = 22;   // bytes that carry packed channel fields
   localparam int NUM_FIELDS  = 16;
   localparam int FIELD_W     = 11;
   localparam int PACKED_W    = NUM_FIELDS * FIELD_W;
   localparam int FLAGS_W     = 3;
   localparam int CSR_INDEX_W = 8;
   localparam int COUNT_W     = 5;
   localparam int INDEX_W     = 5;
   localparam int VALUE_W     = 12;
   localparam int CALC_W      = 13;

   // Flag byte bits
   localparam int FLAG_DIG0     = 0;
   localparam int FLAG_DIG1     = 1;
   localparam int FLAG_FAILSAFE = 2;

   typedef logic [BYTE_W-1:0]         byte_type;
   typedef logic [INDEX_W-1:0]        index_type;
   typedef logic signed [VALUE_W-1:0] value_type;
   typedef logic [COUNT_W-1:0]        count_type;

   // Register index codes
   localparam logic [CSR_INDEX_W-1:0] CSR_START_BYTE = 8'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_END_BYTE   = 8'd1;

   localparam byte_type START_BYTE_RESET = 8'd15;
   localparam byte_type END_BYTE_RESET   = 8'd0;

   // Channel numbers with special mapping
   localparam index_type CH_THROTTLE = 5'd0;
   localparam index_type CH_ROLL     = 5'd1;
   localparam index_type CH_PITCH    = 5'd2;
   localparam index_type CH_YAW      = 5'd3;
   localparam index_type CH_DIG0     = 5'd16;
   localparam index_type CH_DIG1     = 5'd17;

   localparam logic [CALC_W-1:0] CH0_BIAS = 13'd1696;
   localparam logic [CALC_W-1:0] MID_BIAS = 13'd1024;
   localparam value_type DIG_HIGH = 12'sd800;
   localparam value_type DIG_LOW  = -12'sd800;

   typedef enum logic [1:0] {
      PH_WAIT_START = 2'd0,
      PH_DATA       = 2'd1,
      PH_WAIT_END   = 2'd2
   } phase_type;

   typedef struct packed {
      logic                   valid;
      logic [CSR_INDEX_W-1:0] reg_index;
      byte_type               wdata;
   } csr_write_type;

   typedef struct packed {
      logic [FLAGS_W-1:0]  flags;
      logic [PACKED_W-1:0] packed_fields;
   } frame_type;

endpackage

@@ hdl/sfd_interfaces.sv @@
// Channel interfaces of the serial frame decoder: byte input, result output
// and register write port. Depends on sfd_pkg.
interface sfd_req_if import sfd_pkg::*; ();
   logic     valid;
   logic     ready;
   byte_type byte_in;
   modport source (output valid, output byte_in, input ready);
   modport sink   (input valid, input byte_in, output ready);
endinterface

interface sfd_rsp_if import sfd_pkg::*; ();
   logic      valid;
   logic      ready;
   logic      frame_status;
   index_type channel_index;
   value_type channel_value;
   logic      last_of_frame;
   modport source (output valid, output frame_status, output channel_index,
                   output channel_value, output last_of_frame, input ready);
   modport sink   (input valid, input frame_status, input channel_index,
                   input channel_value, input last_of_frame, output ready);
endinterface

interface sfd_csr_if import sfd_pkg::*; ();
   logic                   valid;
   logic                   ready;
   logic [CSR_INDEX_W-1:0] reg_index;
   byte_type               wdata;
   modport source (output valid, output reg_index, output wdata, input ready);
   modport sink   (input valid, input reg_index, input wdata, output ready);
endinterface

@@ hdl/sfd_front.sv @@
// Front end: frame sync, byte collection, end-byte check and frame push.
// Holds the start/end byte registers. Depends on sfd_pkg.
module sfd_front import sfd_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_ready,
   input  byte_type      req_byte,
   input  csr_write_type csr_wr,
   output logic          push_valid,
   input  logic          push_ready,
   output frame_type     push_frame
);

   phase_type phase_ff, phase_in;
   count_type count_ff, count_in;
   byte_type  start_ff, start_in;
   byte_type  end_ff, end_in;
   byte_type  store_ff [PAYLOAD_LEN];
   logic      accept;
   logic      store_we;

   // Stall only when a closing byte arrives and the queue is full.
   assign req_ready  = (phase_ff != PH_WAIT_END) || push_ready;
   assign accept     = req_valid && req_ready;
   assign push_valid = req_valid && (phase_ff == PH_WAIT_END) && (req_byte == end_ff);

   always_comb begin
      phase_in = phase_ff;
      count_in = count_ff;
      store_we = 1'b0;
      case (phase_ff)
         PH_DATA: begin
            if (accept) begin
               store_we = (count_ff < COUNT_W'(PAYLOAD_LEN));
               count_in = count_ff + 1'b1;
               if (count_in >= COUNT_W'(PAYLOAD_LEN)) begin
                  phase_in = PH_WAIT_END;
               end
            end
         end
         PH_WAIT_END: begin
            if (accept) begin
               phase_in = PH_WAIT_START;
            end
         end
         default: begin
            if (accept) begin
               phase_in = PH_WAIT_START;
               if (req_byte == start_ff) begin
                  phase_in = PH_DATA;
                  count_in = '0;
               end
            end
         end
      endcase
   end

   always_comb begin
      start_in = start_ff;
      end_in   = end_ff;
      if (csr_wr.valid) begin
         if (csr_wr.reg_index == CSR_START_BYTE) begin
            start_in = csr_wr.wdata;
         end else if (csr_wr.reg_index == CSR_END_BYTE) begin
            end_in = csr_wr.wdata;
         end
      end
   end

   always_comb begin
      push_frame.flags = store_ff[FLAG_BYTE][FLAGS_W-1:0];
      for (int i = 0; i < DATA_BYTES; i++) begin
         push_frame.packed_fields[i*BYTE_W +: BYTE_W] = store_ff[i];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_WAIT_START;
         count_ff <= '0;
         start_ff <= START_BYTE_RESET;
         end_ff   <= END_BYTE_RESET;
      end else begin
         phase_ff <= phase_in;
         count_ff <= count_in;
         start_ff <= start_in;
         end_ff   <= end_in;
      end
   end

   always_ff @(posedge clock) begin
      if (store_we) begin
         store_ff[count_ff] <= req_byte;
      end
   end

endmodule

@@ hdl/sfd_queue.sv @@
// Short frame queue between front and back end, register based.
// Depends on sfd_pkg.
module sfd_queue import sfd_pkg::*; #(
   parameter int DEPTH = 2
) (
   input  logic      clock,
   input  logic      reset,
   input  logic      push_valid,
   output logic      push_ready,
   input  frame_type push_frame,
   output logic      pop_valid,
   input  logic      pop_ready,
   output frame_type pop_frame
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

   frame_type        entry_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             do_push, do_pop;

   assign push_ready = (cnt_ff != FULL_CNT);
   assign pop_valid  = (cnt_ff != '0);
   assign pop_frame  = entry_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      cnt_in    = cnt_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_frame;
      end
   end

endmodule

@@ hdl/sfd_back.sv @@
// Back end: walks the queue head frame channel by channel and drives the
// registered result stage. Depends on sfd_pkg.
module sfd_back import sfd_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   input  logic      head_valid,
   output logic      head_pop,
   input  frame_type head_frame,
   output logic      rsp_valid,
   input  logic      rsp_ready,
   output logic      rsp_status,
   output index_type rsp_index,
   output value_type rsp_value,
   output logic      rsp_last
);

   index_type          ch_ff, ch_in;
   logic               valid_ff, valid_in;
   logic               status_ff;
   index_type          index_ff;
   value_type          value_ff;
   logic               last_ff;
   logic               load;
   logic [FIELD_W-1:0] fld [NUM_FIELDS];
   logic [FIELD_W-1:0] raw;
   logic [CALC_W-1:0]  raw_x;
   logic               nx_status;
   index_type          nx_index;
   value_type          nx_value;
   logic               nx_last;

   assign load     = head_valid && (!valid_ff || rsp_ready);
   assign head_pop = load && nx_last;

   always_comb begin
      for (int k = 0; k < NUM_FIELDS; k++) begin
         fld[k] = head_frame.packed_fields[k*FIELD_W +: FIELD_W];
      end
   end

   // Field used by each channel: the first three are reordered; yaw keeps field 3.
   always_comb begin
      case (ch_ff)
         CH_THROTTLE: raw = fld[2];
         CH_ROLL:     raw = fld[0];
         CH_PITCH:    raw = fld[1];
         CH_YAW:      raw = fld[3];
         default:     raw = fld[ch_ff[3:0]];
      endcase
      raw_x = {{(CALC_W-FIELD_W){1'b0}}, raw};
   end

   always_comb begin
      nx_status = 1'b0;
      nx_index  = ch_ff;
      nx_last   = (ch_ff == CH_DIG1);
      if (head_frame.flags[FLAG_FAILSAFE]) begin
         nx_status = 1'b1;
         nx_index  = CH_THROTTLE;
         nx_value  = '0;
         nx_last   = 1'b1;
      end else begin
         case (ch_ff)
            CH_THROTTLE: nx_value = value_type'(CH0_BIAS - raw_x);
            CH_ROLL,
            CH_PITCH,
            CH_YAW:      nx_value = value_type'(raw_x - MID_BIAS);
            CH_DIG0:     nx_value = head_frame.flags[FLAG_DIG0] ? DIG_HIGH : DIG_LOW;
            CH_DIG1:     nx_value = head_frame.flags[FLAG_DIG1] ? DIG_HIGH : DIG_LOW;
            default:     nx_value = value_type'(MID_BIAS - raw_x);
         endcase
      end
   end

   always_comb begin
      ch_in    = ch_ff;
      valid_in = valid_ff;
      if (load) begin
         ch_in    = nx_last ? '0 : ch_ff + 1'b1;
         valid_in = 1'b1;
      end else if (rsp_ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ch_ff    <= '0;
         valid_ff <= 1'b0;
      end else begin
         ch_ff    <= ch_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         status_ff <= nx_status;
         index_ff  <= nx_index;
         value_ff  <= nx_value;
         last_ff   <= nx_last;
      end
   end

   assign rsp_valid  = valid_ff;
   assign rsp_status = status_ff;
   assign rsp_index  = index_ff;
   assign rsp_value  = value_ff;
   assign rsp_last   = last_ff;

endmodule

@@ hdl/sbus_frame_decoder.sv @@
// Top level of the serial frame decoder: front end, frame queue, back end.
// Depends on sfd_pkg, sfd_interfaces, sfd_front, sfd_queue, sfd_back.
//
//   Channel   Dir  Payload                                             Transfer
//   req_bus   in   byte_in[7:0]                                        valid & ready
//   rsp_bus   out  frame_status, channel_index[4:0],                   valid & ready
//                  channel_value[11:0] signed, last_of_frame
//   csr_bus   in   reg_index[7:0], wdata[7:0]                          valid & ready
//
// One byte transaction per cycle is taken on req_bus; the only stall is a
// closing byte arriving while the frame queue is full.
// A good frame is pushed into the queue when its end byte is taken, and the
// back end then loads its results into the output register, one result per
// cycle while rsp_bus is ready (1 failsafe or 18 channels), paced by the
// back-end channel counter and the single output register.
// Reset (synchronous, active high) clears phase, counters, queue and result
// valid, and loads start byte 15 and end byte 0; the byte store needs none.
// rsp_bus stalls hold the output register and back up into the queue; a full queue stalls the closing byte on req_bus.
module sbus_frame_decoder import sfd_pkg::*; #(
   parameter int QUEUE_DEPTH = 2
) (
   input logic         clock,
   input logic         reset,
   sfd_req_if.sink     req_bus,
   sfd_rsp_if.source   rsp_bus,
   sfd_csr_if.sink     csr_bus
);

   csr_write_type csr_wr;
   logic          push_valid, push_ready;
   frame_type     push_frame;
   logic          head_valid, head_pop;
   frame_type     head_frame;

   // Registers take a write every cycle.
   assign csr_bus.ready    = 1'b1;
   assign csr_wr.valid     = csr_bus.valid;
   assign csr_wr.reg_index = csr_bus.reg_index;
   assign csr_wr.wdata     = csr_bus.wdata;

   // Sync, collect and check frames.
   sfd_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_bus.valid),
      .req_ready  (req_bus.ready),
      .req_byte   (req_bus.byte_in),
      .csr_wr     (csr_wr),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_frame (push_frame)
   );

   // Decouple byte intake from result delivery.
   sfd_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_frame (push_frame),
      .pop_valid  (head_valid),
      .pop_ready  (head_pop),
      .pop_frame  (head_frame)
   );

   // Unpack channels and serialize them onto rsp_bus.
   sfd_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head_valid (head_valid),
      .head_pop   (head_pop),
      .head_frame (head_frame),
      .rsp_valid  (rsp_bus.valid),
      .rsp_ready  (rsp_bus.ready),
      .rsp_status (rsp_bus.frame_status),
      .rsp_index  (rsp_bus.channel_index),
      .rsp_value  (rsp_bus.channel_value),
      .rsp_last   (rsp_bus.last_of_frame)
   );

endmodule

@@ hdl/sfd_checker.sv @@
// Port-level checks on the result channel of the serial frame decoder, with
// the bind that attaches them to the top level. Depends on sfd_pkg.
module sfd_checker import sfd_pkg::*; (
   input logic      clock,
   input logic      reset,
   input logic      rsp_valid,
   input logic      rsp_ready,
   input logic      frame_status,
   input index_type channel_index,
   input value_type channel_value,
   input logic      last_of_frame
);

   // Hold a stalled result.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(channel_index)
         && $stable(channel_value) && $stable(frame_status) && $stable(last_of_frame))
      else $error("stalled result changed");

   // A failsafe result stands alone.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && frame_status |-> channel_index == CH_THROTTLE
         && channel_value == '0 && last_of_frame)
      else $error("malformed failsafe result");

   // Channel frames end exactly on the last digital flag.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !frame_status |-> last_of_frame == (channel_index == CH_DIG1))
      else $error("frame end marker misplaced");

   // Channels advance one by one inside a frame.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && !last_of_frame && !frame_status |=>
         !rsp_valid || (channel_index == $past(channel_index) + 5'd1))
      else $error("channel sequence broken");

endmodule

bind sbus_frame_decoder sfd_checker u_sfd_checker (
   .clock         (clock),
   .reset         (reset),
   .rsp_valid     (rsp_bus.valid),
   .rsp_ready     (rsp_bus.ready),
   .frame_status  (rsp_bus.frame_status),
   .channel_index (rsp_bus.channel_index),
   .channel_value (rsp_bus.channel_value),
   .last_of_frame (rsp_bus.last_of_frame)
);
